// ===== rtl/y86e_pkg.sv =====
// Shared types and constants for the Y86-64 execute stage.
`default_nettype none
package y86e_pkg;

  typedef logic [1:0]  stat_t;
  typedef logic [3:0]  icode_t;
  typedef logic [3:0]  ifun_t;
  typedef logic [3:0]  reg_id_t;
  typedef logic [63:0] word_t;

  localparam stat_t   STAT_AOK = 2'd0;

  localparam icode_t  I_NOP    = 4'd1;
  localparam icode_t  I_RRMOVQ = 4'd2;
  localparam icode_t  I_IRMOVQ = 4'd3;
  localparam icode_t  I_RMMOVQ = 4'd4;
  localparam icode_t  I_MRMOVQ = 4'd5;
  localparam icode_t  I_OPQ    = 4'd6;
  localparam icode_t  I_JXX    = 4'd7;
  localparam icode_t  I_CALL   = 4'd8;
  localparam icode_t  I_RET    = 4'd9;
  localparam icode_t  I_PUSHQ  = 4'd10;
  localparam icode_t  I_POPQ   = 4'd11;

  localparam ifun_t   ALU_ADD  = 4'd0;
  localparam ifun_t   ALU_SUB  = 4'd1;
  localparam ifun_t   ALU_AND  = 4'd2;
  localparam ifun_t   ALU_XOR  = 4'd3;

  localparam ifun_t   C_ALWAYS = 4'd0;
  localparam ifun_t   C_LE     = 4'd1;
  localparam ifun_t   C_L      = 4'd2;
  localparam ifun_t   C_E      = 4'd3;
  localparam ifun_t   C_NE     = 4'd4;
  localparam ifun_t   C_GE     = 4'd5;
  localparam ifun_t   C_G      = 4'd6;

  localparam reg_id_t REG_NONE = 4'd15;

  localparam word_t   STACK_DEC = 64'hFFFF_FFFF_FFFF_FFF8;
  localparam word_t   STACK_INC = 64'd8;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } flags_t;

endpackage
`default_nettype wire

// ===== rtl/y86e_alu.sv =====
// Operand selection, ALU and condition code generation.
`default_nettype none
module y86e_alu (
  input  y86e_pkg::icode_t icode,
  input  y86e_pkg::ifun_t  ifun,
  input  y86e_pkg::word_t  val_c,
  input  y86e_pkg::word_t  val_a,
  input  y86e_pkg::word_t  val_b,
  output y86e_pkg::word_t  val_e,
  output y86e_pkg::flags_t cc_new
);
  import y86e_pkg::*;

  word_t alu_a;
  word_t alu_b;
  ifun_t alu_fn;
  word_t sum;
  word_t diff;
  logic  ovf;

  always_comb begin
    case (icode)
      I_RRMOVQ, I_OPQ:            alu_a = val_a;
      I_IRMOVQ, I_RMMOVQ, I_MRMOVQ: alu_a = val_c;
      I_CALL, I_PUSHQ:            alu_a = STACK_DEC;
      I_RET, I_POPQ:              alu_a = STACK_INC;
      default:                    alu_a = '0;
    endcase
  end

  always_comb begin
    case (icode)
      I_RMMOVQ, I_MRMOVQ, I_OPQ, I_CALL, I_PUSHQ, I_RET, I_POPQ: alu_b = val_b;
      default: alu_b = '0;
    endcase
  end

  assign alu_fn = (icode == I_OPQ) ? ifun : ALU_ADD;
  assign sum    = alu_a + alu_b;
  assign diff   = alu_b - alu_a;

  always_comb begin
    case (alu_fn)
      ALU_SUB: begin
        val_e = diff;
        ovf   = (alu_a[63] ^ alu_b[63]) & (diff[63] ^ alu_b[63]);
      end
      ALU_AND: begin
        val_e = alu_a & alu_b;
        ovf   = 1'b0;
      end
      ALU_XOR: begin
        val_e = alu_a ^ alu_b;
        ovf   = 1'b0;
      end
      default: begin
        val_e = sum;
        ovf   = ~(alu_a[63] ^ alu_b[63]) & (sum[63] ^ alu_a[63]);
      end
    endcase
  end

  assign cc_new.zf = (val_e == '0);
  assign cc_new.sf = val_e[63];
  assign cc_new.of = ovf;

endmodule
`default_nettype wire

// ===== rtl/y86e_cond.sv =====
// Jump and conditional move condition evaluation from stored flags.
`default_nettype none
module y86e_cond (
  input  y86e_pkg::icode_t icode,
  input  y86e_pkg::ifun_t  ifun,
  input  y86e_pkg::flags_t cc,
  output logic             taken
);
  import y86e_pkg::*;

  logic lt;
  logic hit;

  assign lt = cc.sf ^ cc.of;

  always_comb begin
    unique case (ifun)
      C_ALWAYS: hit = 1'b1;
      C_LE:     hit = lt | cc.zf;
      C_L:      hit = lt;
      C_E:      hit = cc.zf;
      C_NE:     hit = ~cc.zf;
      C_GE:     hit = ~lt;
      C_G:      hit = ~lt & ~cc.zf;
      default:  hit = 1'b0;
    endcase
  end

  assign taken = hit & ((icode == I_JXX) | (icode == I_RRMOVQ));

endmodule
`default_nettype wire

// ===== rtl/y86_pipeline_execute_stage_unit.sv =====
// Y86-64 pipeline execute stage: input register, ALU/condition logic, result register.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | status, code, func, valC, valA, valB, dsts, later stats
//   out     | out_valid / out_ready| status, code, cond, valE, valA, dsts, bubble
//
// Results pass input then result register; one item per cycle while out_ready is high.
// The input register and the result register each advance when the stage after is free;
// in_ready drops only while both hold an item and out_ready is low.
// Synchronous active-low reset clears both valid bits and sets flags to ZF=1, SF=0, OF=0.
// Flags update as a non-bubble OPq item moves into the result register, so the next item sees them.
`default_nettype none
module y86_pipeline_execute_stage_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  y86e_pkg::stat_t    in_instr_status,
  input  y86e_pkg::icode_t   in_instr_code,
  input  y86e_pkg::ifun_t    in_instr_func,
  input  y86e_pkg::word_t    in_const_value,
  input  y86e_pkg::word_t    in_operand_a,
  input  y86e_pkg::word_t    in_operand_b,
  input  y86e_pkg::reg_id_t  in_dest_e_reg,
  input  y86e_pkg::reg_id_t  in_dest_m_reg,
  input  y86e_pkg::stat_t    in_mem_stage_status,
  input  y86e_pkg::stat_t    in_wb_stage_status,
  output logic               out_valid,
  input  wire                out_ready,
  output y86e_pkg::stat_t    out_status,
  output y86e_pkg::icode_t   out_code,
  output logic               out_cond_taken,
  output y86e_pkg::word_t    out_alu_result,
  output y86e_pkg::word_t    out_pass_operand_a,
  output y86e_pkg::reg_id_t  out_dest_e,
  output y86e_pkg::reg_id_t  out_dest_m,
  output logic               out_is_bubble
);
  import y86e_pkg::*;

  logic    s1_valid_r;
  stat_t   stat_r;
  icode_t  icode_r;
  ifun_t   ifun_r;
  word_t   valc_r;
  word_t   vala_r;
  word_t   valb_r;
  reg_id_t dste_r;
  reg_id_t dstm_r;
  stat_t   mstat_r;
  stat_t   wstat_r;

  flags_t  cc_r;
  flags_t  cc_nxt;

  logic    ov_r;
  stat_t   o_stat_r;
  icode_t  o_code_r;
  logic    o_cnd_r;
  word_t   o_vale_r;
  word_t   o_vala_r;
  reg_id_t o_dste_r;
  reg_id_t o_dstm_r;
  logic    o_bub_r;

  logic    s1_adv;
  logic    in_xfer;
  logic    bubble;
  logic    cnd;
  word_t   val_e;
  flags_t  cc_new;
  reg_id_t dste_eff;

  assign s1_adv   = s1_valid_r & (~ov_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;
  assign in_xfer  = in_valid & in_ready;

  y86e_alu u_alu (
    .icode  (icode_r),
    .ifun   (ifun_r),
    .val_c  (valc_r),
    .val_a  (vala_r),
    .val_b  (valb_r),
    .val_e  (val_e),
    .cc_new (cc_new)
  );

  y86e_cond u_cond (
    .icode (icode_r),
    .ifun  (ifun_r),
    .cc    (cc_r),
    .taken (cnd)
  );

  assign bubble   = (mstat_r != STAT_AOK) | (wstat_r != STAT_AOK);
  assign dste_eff = ((icode_r == I_RRMOVQ) && !cnd) ? REG_NONE : dste_r;

  always_comb begin
    cc_nxt = cc_r;
    if (s1_adv && (icode_r == I_OPQ) && !bubble) begin
      cc_nxt = cc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ov_r       <= 1'b0;
      cc_r       <= '{zf: 1'b1, sf: 1'b0, of: 1'b0};
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (~ov_r | out_ready) begin
        ov_r <= s1_valid_r;
      end
      cc_r <= cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stat_r  <= in_instr_status;
      icode_r <= in_instr_code;
      ifun_r  <= in_instr_func;
      valc_r  <= in_const_value;
      vala_r  <= in_operand_a;
      valb_r  <= in_operand_b;
      dste_r  <= in_dest_e_reg;
      dstm_r  <= in_dest_m_reg;
      mstat_r <= in_mem_stage_status;
      wstat_r <= in_wb_stage_status;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (bubble) begin
        o_stat_r <= STAT_AOK;
        o_code_r <= I_NOP;
        o_cnd_r  <= 1'b0;
        o_vale_r <= '0;
        o_vala_r <= '0;
        o_dste_r <= REG_NONE;
        o_dstm_r <= REG_NONE;
        o_bub_r  <= 1'b1;
      end else begin
        o_stat_r <= stat_r;
        o_code_r <= icode_r;
        o_cnd_r  <= cnd;
        o_vale_r <= val_e;
        o_vala_r <= vala_r;
        o_dste_r <= dste_eff;
        o_dstm_r <= dstm_r;
        o_bub_r  <= 1'b0;
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = o_stat_r;
  assign out_code           = o_code_r;
  assign out_cond_taken     = o_cnd_r;
  assign out_alu_result     = o_vale_r;
  assign out_pass_operand_a = o_vala_r;
  assign out_dest_e         = o_dste_r;
  assign out_dest_m         = o_dstm_r;
  assign out_is_bubble      = o_bub_r;

endmodule
`default_nettype wire
